@@ hdl/sttq_pkg.sv @@
// ============================================================================
// sttq_pkg
// Types and constants for the sorted timer task queue.
// ============================================================================
package sttq_pkg;

    localparam int unsigned TIME_W = 56;
    localparam int unsigned ID_W   = 8;

    // Most tasks popped by one fire command.
    localparam int unsigned MAX_OUT = 16;

    // Delay reported for an empty queue: 2^30 s in microseconds.
    localparam logic [TIME_W-1:0] EMPTY_DELAY = 56'd1073741824000000;

    typedef enum logic [2:0] {
        CMD_INSERT   = 3'd0,
        CMD_RM_OWNER = 3'd1,
        CMD_RM_TYPE  = 3'd2,
        CMD_QUERY    = 3'd3,
        CMD_FIRE     = 3'd4,
        CMD_DELAY    = 3'd5
    } cmd_t;

    typedef struct packed {
        logic [TIME_W-1:0] due;
        logic [ID_W-1:0]   owner;
        logic [ID_W-1:0]   kind;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_USE,
        ST_RM_RD,
        ST_RM_USE,
        ST_QRY_RD,
        ST_QRY_USE,
        ST_FCNT_RD,
        ST_FCNT_USE,
        ST_EMIT_RD,
        ST_EMIT_USE,
        ST_CPY_RD,
        ST_CPY_USE,
        ST_DLY_RD,
        ST_DLY_USE,
        ST_RESP
    } state_t;

endpackage

@@ hdl/sorted_timer_task_queue_top.sv @@
// ============================================================================
// sorted_timer_task_queue_top
// Due-time ordered task queue kept in one synchronous memory.
// ============================================================================
// Each command steps through read/use state pairs: insert walks down from the tail past
//   later entries (a full insert goes straight to its result), remove scans all n, query
//   stops at its first match, delay reads the head if any, and fire counts the due prefix
//   (at most 16), emits one result per due task and shifts the survivors down; m_tready
//   stalls add on. One command at a time; the next is accepted once the last result is
//   registered or a fire's copy pass ends. Reset (sync): queue and output empty, memory kept.

module sorted_timer_task_queue_top #(
    parameter int unsigned DEPTH = 16
) (
    input  logic         aclk,
    input  logic         aresetn,

    // Command items
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,  // owner[7:0], task_type[15:8], due_time[71:16], now[127:72]
    input  logic [2:0]   s_tuser,  // command[2:0]

    // Result items
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [79:0]  m_tdata,  // out_owner[7:0], out_type[15:8], found[16],
                                   // time_value[72:17], full_error[73], zero pad[79:74]
    output logic         m_tlast   // last
);

    localparam int unsigned CW = $clog2(DEPTH + 1);  // counts 0..DEPTH
    localparam int unsigned IW = $clog2(DEPTH);      // memory address

    localparam int unsigned TW = sttq_pkg::TIME_W;
    localparam int unsigned DW = sttq_pkg::ID_W;

    // ------------------------------------------------------------------
    // Input field split
    // ------------------------------------------------------------------
    logic [DW-1:0] s_owner;
    logic [DW-1:0] s_type;
    logic [TW-1:0] s_due;
    logic [TW-1:0] s_now;

    assign s_owner = s_tdata[7:0];
    assign s_type  = s_tdata[15:8];
    assign s_due   = s_tdata[71:16];
    assign s_now   = s_tdata[127:72];

    // ------------------------------------------------------------------
    // Task memory: one write and one read port, registered read data.
    // The sequencer never reads and writes in the same cycle, so no
    // same-entry forwarding is needed.
    // ------------------------------------------------------------------
    sttq_pkg::entry_t mem [DEPTH];
    sttq_pkg::entry_t rdata_reg;

    logic             mem_we;
    logic [IW-1:0]    mem_waddr;
    sttq_pkg::entry_t mem_wdata;
    logic             mem_re;
    logic [IW-1:0]    mem_raddr;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    sttq_pkg::state_t state_reg, state_next;
    logic [CW-1:0]    cnt_reg, cnt_next;      // queued tasks
    logic [CW-1:0]    idx_reg, idx_next;      // scan pointer
    logic [CW-1:0]    wr_reg, wr_next;        // compaction write pointer
    logic [CW-1:0]    nfire_reg, nfire_next;  // tasks popped by this fire

    // Latched command payload
    logic [DW-1:0]    own_reg, own_next;
    logic [DW-1:0]    typ_reg, typ_next;
    logic [TW-1:0]    due_reg, due_next;
    logic [TW-1:0]    now_reg, now_next;
    logic             by_type_reg, by_type_next;

    // Staged single-result fields
    logic             rs_found_reg, rs_found_next;
    logic [TW-1:0]    rs_time_reg, rs_time_next;
    logic             rs_full_reg, rs_full_next;

    // Output register
    logic             m_valid_reg, m_valid_next;
    logic [DW-1:0]    m_owner_reg, m_owner_next;
    logic [DW-1:0]    m_type_reg, m_type_next;
    logic             m_found_reg, m_found_next;
    logic [TW-1:0]    m_time_reg, m_time_next;
    logic             m_full_reg, m_full_next;
    logic             m_last_reg, m_last_next;

    logic             out_free;
    logic             rd_match;
    logic             rd_expired;
    logic             fire_stop;
    sttq_pkg::entry_t new_entry;

    assign out_free   = !m_valid_reg || m_tready;
    assign rd_match   = (rdata_reg.owner == own_reg) &&
                        (!by_type_reg || (rdata_reg.kind == typ_reg));
    assign rd_expired = rdata_reg.due < now_reg;
    assign fire_stop  = (idx_reg == cnt_reg) || (32'(idx_reg) == sttq_pkg::MAX_OUT);
    assign new_entry  = '{due: due_reg, owner: own_reg, kind: typ_reg};

    assign s_tready = (state_reg == sttq_pkg::ST_IDLE);

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        wr_next       = wr_reg;
        nfire_next    = nfire_reg;
        own_next      = own_reg;
        typ_next      = typ_reg;
        due_next      = due_reg;
        now_next      = now_reg;
        by_type_next  = by_type_reg;
        rs_found_next = rs_found_reg;
        rs_time_next  = rs_time_reg;
        rs_full_next  = rs_full_reg;

        m_valid_next  = m_valid_reg && !m_tready;
        m_owner_next  = m_owner_reg;
        m_type_next   = m_type_reg;
        m_found_next  = m_found_reg;
        m_time_next   = m_time_reg;
        m_full_next   = m_full_reg;
        m_last_next   = m_last_reg;

        mem_we    = 1'b0;
        mem_waddr = idx_reg[IW-1:0];
        mem_wdata = rdata_reg;
        mem_re    = 1'b0;
        mem_raddr = idx_reg[IW-1:0];

        unique case (state_reg)
            sttq_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    own_next      = s_owner;
                    typ_next      = s_type;
                    due_next      = s_due;
                    now_next      = s_now;
                    rs_found_next = 1'b0;
                    rs_time_next  = '0;
                    rs_full_next  = 1'b0;
                    idx_next      = '0;
                    wr_next       = '0;
                    by_type_next  = 1'b1;
                    unique case (s_tuser)
                        sttq_pkg::CMD_INSERT: begin
                            if (cnt_reg == CW'(DEPTH)) begin
                                rs_full_next = 1'b1;
                                state_next   = sttq_pkg::ST_RESP;
                            end else begin
                                idx_next   = cnt_reg;
                                state_next = sttq_pkg::ST_INS_RD;
                            end
                        end
                        sttq_pkg::CMD_RM_OWNER: begin
                            by_type_next = 1'b0;
                            state_next   = sttq_pkg::ST_RM_RD;
                        end
                        sttq_pkg::CMD_RM_TYPE:  state_next = sttq_pkg::ST_RM_RD;
                        sttq_pkg::CMD_QUERY:    state_next = sttq_pkg::ST_QRY_RD;
                        sttq_pkg::CMD_FIRE:     state_next = sttq_pkg::ST_FCNT_RD;
                        sttq_pkg::CMD_DELAY:    state_next = sttq_pkg::ST_DLY_RD;
                        default:                state_next = sttq_pkg::ST_RESP;
                    endcase
                end
            end

            // Insert: walk down from the tail, moving later entries up one.
            sttq_pkg::ST_INS_RD: begin
                if (idx_reg == '0) begin
                    mem_we     = 1'b1;
                    mem_waddr  = '0;
                    mem_wdata  = new_entry;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = sttq_pkg::ST_RESP;
                end else begin
                    mem_re     = 1'b1;
                    mem_raddr  = IW'(idx_reg - 1'b1);
                    state_next = sttq_pkg::ST_INS_USE;
                end
            end
            sttq_pkg::ST_INS_USE: begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg[IW-1:0];
                if (rdata_reg.due > due_reg) begin
                    mem_wdata  = rdata_reg;
                    idx_next   = idx_reg - 1'b1;
                    state_next = sttq_pkg::ST_INS_RD;
                end else begin
                    mem_wdata  = new_entry;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = sttq_pkg::ST_RESP;
                end
            end

            // Remove: compact non-matching entries toward the head.
            sttq_pkg::ST_RM_RD: begin
                if (idx_reg == cnt_reg) begin
                    cnt_next   = wr_reg;
                    state_next = sttq_pkg::ST_RESP;
                end else begin
                    mem_re     = 1'b1;
                    state_next = sttq_pkg::ST_RM_USE;
                end
            end
            sttq_pkg::ST_RM_USE: begin
                if (!rd_match) begin
                    mem_we    = 1'b1;
                    mem_waddr = wr_reg[IW-1:0];
                    wr_next   = wr_reg + 1'b1;
                end
                idx_next   = idx_reg + 1'b1;
                state_next = sttq_pkg::ST_RM_RD;
            end

            // Query: first entry matching owner and type.
            sttq_pkg::ST_QRY_RD: begin
                if (idx_reg == cnt_reg) begin
                    state_next = sttq_pkg::ST_RESP;
                end else begin
                    mem_re     = 1'b1;
                    state_next = sttq_pkg::ST_QRY_USE;
                end
            end
            sttq_pkg::ST_QRY_USE: begin
                if (rd_match) begin
                    rs_found_next = 1'b1;
                    rs_time_next  = rdata_reg.due;
                    state_next    = sttq_pkg::ST_RESP;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = sttq_pkg::ST_QRY_RD;
                end
            end

            // Fire, pass 1: length of the expired prefix, capped.
            sttq_pkg::ST_FCNT_RD: begin
                if (fire_stop) begin
                    nfire_next = idx_reg;
                    if (idx_reg == '0) begin
                        state_next = sttq_pkg::ST_RESP;
                    end else begin
                        idx_next   = '0;
                        state_next = sttq_pkg::ST_EMIT_RD;
                    end
                end else begin
                    mem_re     = 1'b1;
                    state_next = sttq_pkg::ST_FCNT_USE;
                end
            end
            sttq_pkg::ST_FCNT_USE: begin
                if (rd_expired) begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = sttq_pkg::ST_FCNT_RD;
                end else begin
                    nfire_next = idx_reg;
                    if (idx_reg == '0) begin
                        state_next = sttq_pkg::ST_RESP;
                    end else begin
                        idx_next   = '0;
                        state_next = sttq_pkg::ST_EMIT_RD;
                    end
                end
            end

            // Fire, pass 2: one result item per popped task.
            sttq_pkg::ST_EMIT_RD: begin
                mem_re     = 1'b1;
                state_next = sttq_pkg::ST_EMIT_USE;
            end
            sttq_pkg::ST_EMIT_USE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_owner_next = rdata_reg.owner;
                    m_type_next  = rdata_reg.kind;
                    m_found_next = 1'b1;
                    m_time_next  = '0;
                    m_full_next  = 1'b0;
                    m_last_next  = (idx_reg + 1'b1 == nfire_reg);
                    idx_next     = idx_reg + 1'b1;
                    if (idx_reg + 1'b1 == nfire_reg) begin
                        wr_next    = '0;
                        state_next = sttq_pkg::ST_CPY_RD;
                    end else begin
                        state_next = sttq_pkg::ST_EMIT_RD;
                    end
                end
            end

            // Fire, pass 3: shift the survivors down to the head.
            sttq_pkg::ST_CPY_RD: begin
                if (idx_reg == cnt_reg) begin
                    cnt_next   = wr_reg;
                    state_next = sttq_pkg::ST_IDLE;
                end else begin
                    mem_re     = 1'b1;
                    state_next = sttq_pkg::ST_CPY_USE;
                end
            end
            sttq_pkg::ST_CPY_USE: begin
                mem_we     = 1'b1;
                mem_waddr  = wr_reg[IW-1:0];
                wr_next    = wr_reg + 1'b1;
                idx_next   = idx_reg + 1'b1;
                state_next = sttq_pkg::ST_CPY_RD;
            end

            // Delay to head.
            sttq_pkg::ST_DLY_RD: begin
                if (cnt_reg == '0) begin
                    rs_time_next = sttq_pkg::EMPTY_DELAY;
                    state_next   = sttq_pkg::ST_RESP;
                end else begin
                    mem_re     = 1'b1;
                    mem_raddr  = '0;
                    state_next = sttq_pkg::ST_DLY_USE;
                end
            end
            sttq_pkg::ST_DLY_USE: begin
                rs_time_next = (rdata_reg.due > now_reg) ? (rdata_reg.due - now_reg) : '0;
                state_next   = sttq_pkg::ST_RESP;
            end

            sttq_pkg::ST_RESP: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_owner_next = '0;
                    m_type_next  = '0;
                    m_found_next = rs_found_reg;
                    m_time_next  = rs_time_reg;
                    m_full_next  = rs_full_reg;
                    m_last_next  = 1'b1;
                    state_next   = sttq_pkg::ST_IDLE;
                end
            end

            default: state_next = sttq_pkg::ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sttq_pkg::ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload and pointer registers
    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        wr_reg       <= wr_next;
        nfire_reg    <= nfire_next;
        own_reg      <= own_next;
        typ_reg      <= typ_next;
        due_reg      <= due_next;
        now_reg      <= now_next;
        by_type_reg  <= by_type_next;
        rs_found_reg <= rs_found_next;
        rs_time_reg  <= rs_time_next;
        rs_full_reg  <= rs_full_next;
        m_owner_reg  <= m_owner_next;
        m_type_reg   <= m_type_next;
        m_found_reg  <= m_found_next;
        m_time_reg   <= m_time_next;
        m_full_reg   <= m_full_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {6'b0, m_full_reg, m_time_reg, m_found_reg, m_type_reg, m_owner_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(DEPTH))
        else $error("task count above DEPTH");

    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_we && mem_re))
        else $error("memory read and write in the same cycle");

    a_cnt_grows_by_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sttq_pkg::ST_IDLE && s_tvalid) |=> (cnt_reg <= $past(cnt_reg) + 1'b1))
        else $error("task count grew by more than one");

    a_fire_only_popped: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_found_reg) |-> (m_owner_reg == '0 && m_type_reg == '0 && m_last_reg))
        else $error("non-fire result carries task fields or is not last");

    a_full_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_full_reg) |-> (m_last_reg && !m_found_reg))
        else $error("full flag on a fired or non-final result");

endmodule

@@ tb/task_queue_sb_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// task_queue_sb_pkg
// Scoreboard for the sorted timer task queue: keeps its own copy of the
// queue, works out the results of every accepted command and checks them.
// ============================================================================
package task_queue_sb_pkg;

    localparam int unsigned TIME_W = sttq_pkg::TIME_W;
    localparam int unsigned ID_W   = sttq_pkg::ID_W;

    typedef logic [TIME_W-1:0] field_t;

    typedef struct packed {
        logic [ID_W-1:0]   out_owner;
        logic [ID_W-1:0]   out_type;
        logic              found;
        logic [TIME_W-1:0] time_value;
        logic              full_error;
        logic              last;
    } task_result_t;

    class task_queue_sb_t;
        int unsigned      depth;
        sttq_pkg::entry_t slots[$];       // due-time ordered, head at index 0
        task_result_t     expected_q[$];  // results still to come, oldest first
        int unsigned      errors;

        function new(int unsigned depth_i);
            depth  = depth_i;
            errors = 0;
        endfunction

        // Applies one accepted command to the queue copy and queues its results.
        function void note_command(logic [2:0] cmd, logic [ID_W-1:0] own,
                                   logic [ID_W-1:0] kind, logic [TIME_W-1:0] due,
                                   logic [TIME_W-1:0] now);
            task_result_t     r;
            sttq_pkg::entry_t e;
            int               pos;
            int               i;
            int unsigned      popped;
            bit               by_type;

            r      = '0;
            r.last = 1'b1;
            case (cmd)
                sttq_pkg::CMD_INSERT: begin
                    if (slots.size() >= depth) begin
                        r.full_error = 1'b1;
                    end else begin
                        // ties go behind existing entries
                        pos = 0;
                        while (pos < slots.size() && slots[pos].due <= due) pos++;
                        e.due   = due;
                        e.owner = own;
                        e.kind  = kind;
                        slots.insert(pos, e);
                    end
                    expected_q.push_back(r);
                end
                sttq_pkg::CMD_RM_OWNER, sttq_pkg::CMD_RM_TYPE: begin
                    by_type = (cmd == sttq_pkg::CMD_RM_TYPE);
                    i = 0;
                    while (i < slots.size()) begin
                        if (slots[i].owner == own && (!by_type || slots[i].kind == kind))
                            slots.delete(i);
                        else
                            i++;
                    end
                    expected_q.push_back(r);
                end
                sttq_pkg::CMD_QUERY: begin
                    for (i = 0; i < slots.size(); i++) begin
                        if (slots[i].owner == own && slots[i].kind == kind) begin
                            r.found      = 1'b1;
                            r.time_value = slots[i].due;
                            break;
                        end
                    end
                    expected_q.push_back(r);
                end
                sttq_pkg::CMD_FIRE: begin
                    popped = 0;
                    while (popped < sttq_pkg::MAX_OUT && slots.size() > 0 &&
                           slots[0].due < now) begin
                        r           = '0;
                        r.out_owner = slots[0].owner;
                        r.out_type  = slots[0].kind;
                        r.found     = 1'b1;
                        expected_q.push_back(r);
                        slots.delete(0);
                        popped++;
                    end
                    if (popped == 0)
                        expected_q.push_back(r);
                    else
                        expected_q[expected_q.size() - 1].last = 1'b1;
                end
                sttq_pkg::CMD_DELAY: begin
                    if (slots.size() == 0)
                        r.time_value = sttq_pkg::EMPTY_DELAY;
                    else if (slots[0].due > now)
                        r.time_value = slots[0].due - now;
                    expected_q.push_back(r);
                end
                default: begin
                    expected_q.push_back(r);
                end
            endcase
        endfunction

        function void compare_field(string name, field_t want, field_t got);
            if (want !== got) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        // Checks one accepted result item against the oldest expectation.
        function void check_result(logic [79:0] data, logic tlast);
            task_result_t want;

            if (expected_q.size() == 0) begin
                $error("result item with nothing expected: tdata=0x%0h last=%0b",
                       data, tlast);
                errors++;
                return;
            end
            want = expected_q[0];
            expected_q.delete(0);
            compare_field("out_owner",  field_t'(want.out_owner),  field_t'(data[7:0]));
            compare_field("out_type",   field_t'(want.out_type),   field_t'(data[15:8]));
            compare_field("found",      field_t'(want.found),      field_t'(data[16]));
            compare_field("time_value", want.time_value,           data[72:17]);
            compare_field("full_error", field_t'(want.full_error), field_t'(data[73]));
            compare_field("last",       field_t'(want.last),       field_t'(tlast));
        endfunction
    endclass

endpackage

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Stream-level test of the sorted timer task queue. Directed commands cover
// the empty queue, ties, strict firing, delays and unknown commands; random
// phases then mix fill bursts, drains and single commands under varying
// sender gaps and receiver stalls, including one long receiver hold-off.
// ============================================================================
module tb_top;

    localparam int unsigned TIME_W          = sttq_pkg::TIME_W;
    localparam int unsigned ID_W            = sttq_pkg::ID_W;
    localparam int unsigned DEPTH           = 16;
    localparam int unsigned ITEMS_PER_PHASE = 20;
    localparam int unsigned HOLD_CYCLES     = 400;
    localparam int unsigned TAIL_CYCLES     = 120;

    // Command codes that the block does not define; they must give a zero result.
    localparam logic [2:0] CMD_UNUSED_6 = 3'd6;
    localparam logic [2:0] CMD_UNUSED_7 = 3'd7;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata  = '0;   // owner[7:0], task_type[15:8], due_time[71:16], now[127:72]
    logic [2:0]   s_tuser  = '0;   // command[2:0]
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [79:0]  m_tdata;         // out_owner, out_type, found, time_value, full_error
    logic         m_tlast;

    task_queue_sb_pkg::task_queue_sb_t sb;
    int unsigned       idle_pct  = 0;    // chance per cycle that the sender holds back
    int unsigned       stall_pct = 0;    // chance per cycle that the receiver stalls
    int unsigned       sent      = 0;    // accepted command items
    logic              holding   = 1'b0; // long receiver hold-off in progress
    logic [TIME_W-1:0] clock_us  = 56'd1000; // notional current time for stimulus
    event              hold_go;

    sorted_timer_task_queue_top #(
        .DEPTH(DEPTH)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Hard stop; far beyond the slowest correct run.
    initial begin
        #1_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Receiver: random stalls, forced low during reset and the long hold-off.
    always @(posedge aclk) begin
        if (!aresetn || holding)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Long hold-off, counted here so the sender keeps pushing meanwhile.
    initial begin
        forever begin
            @(hold_go);
            @(posedge aclk);
            holding <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge aclk);
            holding <= 1'b0;
        end
    end

    // Result monitor: values sampled at the edge are the pre-edge ones.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tlast);
    end

    function automatic logic [TIME_W-1:0] rand56();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[TIME_W-1:0];
    endfunction

    // Mostly a small owner/type pool so removes and queries hit.
    function automatic logic [ID_W-1:0] pick_id();
        if ($urandom_range(7) == 0)
            return ID_W'($urandom_range(255));
        return ID_W'($urandom_range(3));
    endfunction

    function automatic logic [TIME_W-1:0] pick_due();
        int unsigned r;
        r = $urandom_range(31);
        if (r == 0) return TIME_MAX;
        if (r == 1) return '0;
        if (r <= 4) return rand56();
        // equal times exercise first-in-first-out among ties
        if (r <= 12 && sb.slots.size() > 0)
            return sb.slots[$urandom_range(sb.slots.size() - 1)].due;
        return clock_us + TIME_W'($urandom_range(3000));
    endfunction

    function automatic logic [TIME_W-1:0] pick_now();
        int unsigned r;
        r = $urandom_range(7);
        if (r == 0) return rand56();
        if (r == 1 && sb.slots.size() > 0) return sb.slots[0].due;  // head not yet due
        if (r == 2) return TIME_MAX;
        return clock_us + TIME_W'($urandom_range(500));
    endfunction

    // Offers one command item and waits for it to be taken. valid stays high
    // from one item to the next unless the sender decides to idle.
    task automatic send_cmd(input logic [2:0] cmd, input logic [ID_W-1:0] own,
                            input logic [ID_W-1:0] kind, input logic [TIME_W-1:0] due,
                            input logic [TIME_W-1:0] now);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {now, due, kind, own};
        s_tuser  <= cmd;
        do @(posedge aclk); while (!s_tready);
        sb.note_command(cmd, own, kind, due, now);
        sent++;
    endtask

    // Inserts until the queue is full and then one or two more, which drop.
    task automatic fill_burst();
        int unsigned n;
        n = DEPTH - sb.slots.size() + 1 + $urandom_range(1);
        repeat (n) send_cmd(sttq_pkg::CMD_INSERT, pick_id(), pick_id(), pick_due(), rand56());
    endtask

    task automatic random_item();
        logic [2:0]        cmd;
        logic [ID_W-1:0]   own;
        logic [ID_W-1:0]   kind;
        logic [TIME_W-1:0] due;
        logic [TIME_W-1:0] now;
        int unsigned       r;
        int unsigned       idx;

        // unused fields still carry random bits
        due = rand56();
        now = rand56();
        if (sb.slots.size() > 0 && $urandom_range(1) == 1) begin
            idx  = $urandom_range(sb.slots.size() - 1);
            own  = sb.slots[idx].owner;
            kind = sb.slots[idx].kind;
        end else begin
            own  = pick_id();
            kind = pick_id();
        end
        clock_us += TIME_W'($urandom_range(200));
        r = $urandom_range(99);
        if (r < 35) begin
            cmd = sttq_pkg::CMD_INSERT;
            due = pick_due();
        end else if (r < 52) begin
            cmd = sttq_pkg::CMD_FIRE;
            now = pick_now();
        end else if (r < 64) begin
            cmd = sttq_pkg::CMD_QUERY;
        end else if (r < 72) begin
            cmd = sttq_pkg::CMD_RM_OWNER;
        end else if (r < 82) begin
            cmd = sttq_pkg::CMD_RM_TYPE;
        end else if (r < 95) begin
            cmd = sttq_pkg::CMD_DELAY;
            now = pick_now();
        end else begin
            cmd = ($urandom_range(1) == 0) ? CMD_UNUSED_6 : CMD_UNUSED_7;
        end
        send_cmd(cmd, own, kind, due, now);
    endtask

    // One random phase: fill bursts, full drains and single commands.
    task automatic run_phase(input int unsigned idle, input int unsigned stall,
                             input bit pressure);
        int unsigned start;
        int unsigned r;

        idle_pct  = idle;
        stall_pct = stall;
        start     = sent;
        if (pressure) begin
            // fill up, then hold the receiver while a full drain and more follow
            fill_burst();
            -> hold_go;
            send_cmd(sttq_pkg::CMD_FIRE, pick_id(), pick_id(), rand56(), TIME_MAX);
        end
        while (sent - start < ITEMS_PER_PHASE) begin
            r = $urandom_range(99);
            if (r < 8)
                fill_burst();
            else if (r < 14)
                send_cmd(sttq_pkg::CMD_FIRE, pick_id(), pick_id(), rand56(), TIME_MAX);
            else
                random_item();
        end
    endtask

    initial begin
        sb = new(DEPTH);
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ---- directed: no idling on either side ----
        send_cmd(sttq_pkg::CMD_DELAY,  8'd0,  8'd0,  '0,       '0);       // empty: 2^30 s
        send_cmd(sttq_pkg::CMD_FIRE,   8'd0,  8'd0,  '0,       TIME_MAX); // nothing to fire
        send_cmd(sttq_pkg::CMD_QUERY,  8'd0,  8'd0,  '0,       '0);       // no match
        send_cmd(sttq_pkg::CMD_INSERT, 8'hFF, 8'hFF, TIME_MAX, TIME_MAX); // field maxima
        send_cmd(sttq_pkg::CMD_INSERT, 8'd0,  8'd0,  '0,       '0);       // field minima
        send_cmd(sttq_pkg::CMD_INSERT, 8'd1,  8'd1,  56'd100,  '0);
        send_cmd(sttq_pkg::CMD_INSERT, 8'd2,  8'd2,  56'd100,  '0);       // tie, goes behind
        send_cmd(sttq_pkg::CMD_INSERT, 8'd1,  8'd2,  56'd100,  '0);
        send_cmd(sttq_pkg::CMD_QUERY,  8'd2,  8'd2,  '0,       '0);       // found at 100
        send_cmd(sttq_pkg::CMD_DELAY,  8'd0,  8'd0,  '0,       '0);       // head due now: 0
        send_cmd(sttq_pkg::CMD_FIRE,   8'd0,  8'd0,  '0,       56'd100);  // only time 0 fires
        send_cmd(sttq_pkg::CMD_DELAY,  8'd0,  8'd0,  '0,       56'd1);    // 99 to go
        send_cmd(sttq_pkg::CMD_RM_TYPE,  8'd1, 8'd2, '0,       '0);
        send_cmd(sttq_pkg::CMD_QUERY,  8'd1,  8'd2,  '0,       '0);       // removed: no match
        send_cmd(sttq_pkg::CMD_FIRE,   8'd0,  8'd0,  '0,       56'd101);  // ties leave in order
        send_cmd(sttq_pkg::CMD_DELAY,  8'd0,  8'd0,  '0,       56'd5);    // head at max time
        send_cmd(sttq_pkg::CMD_RM_OWNER, 8'hFF, 8'd0, '0,      '0);
        send_cmd(CMD_UNUSED_6, 8'hA5, 8'h5A, TIME_MAX, TIME_MAX);
        send_cmd(CMD_UNUSED_7, 8'h5A, 8'hA5, '0,       '0);

        // ---- random phases ----
        run_phase(0,  0,  1'b1);   // flat out, with the long receiver hold-off
        run_phase(82, 0,  1'b0);   // sparse sender
        run_phase(0,  82, 1'b0);   // slow receiver
        run_phase(36, 36, 1'b0);   // both sides idle at times

        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
